// ===== rtl/opb_pkg.sv =====
// ----------------------------------------------------------------------------
// opb_pkg
// Shared types, codes and sizes for the positional order book core.
// ----------------------------------------------------------------------------
package opb_pkg;

    // Book size and the widths that follow from it
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response words
    localparam int REQ_W   = 2;
    localparam int POS_W   = 16;
    localparam int VAL_W   = 32;
    localparam int ENT_W   = 31;
    localparam int STS_W   = 3;
    localparam int EPOS_W  = 6;
    localparam int ECNT_W  = 6;
    localparam int CMP_W   = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_MODIFY = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_DUMP   = 2'd3
    } req_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK         = 3'd0,
        STS_BAD_POS    = 3'd1,
        STS_BAD_PRICE  = 3'd2,
        STS_BAD_QTY    = 3'd3,
        STS_BAD_ACTION = 3'd4,
        STS_NO_ENTRY   = 3'd5,
        STS_FULL       = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_MOD,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } ctl_state_t;

    typedef struct packed {
        logic [ENT_W-1:0] price;
        logic [ENT_W-1:0] quantity;
    } entry_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] tail;
        entry_t           wr;
        logic             keep_price;
        logic             keep_quantity;
    } cell_ctrl_t;

endpackage

// ===== rtl/opb_ifs.sv =====
// ----------------------------------------------------------------------------
// opb_ifs
// Request and response channels of the order book, valid/ready handshake.
// ----------------------------------------------------------------------------
interface opb_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [opb_pkg::REQ_W-1:0]              req_type;
    logic signed [opb_pkg::POS_W-1:0]       position;
    logic signed [opb_pkg::VAL_W-1:0]       price;
    logic signed [opb_pkg::VAL_W-1:0]       quantity;

    modport source (output valid, req_type, position, price, quantity, input ready);
    modport sink   (input valid, req_type, position, price, quantity, output ready);
endinterface

interface opb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [opb_pkg::STS_W-1:0]          status;
    logic                               has_entry;
    logic [opb_pkg::EPOS_W-1:0]         entry_position;
    logic [opb_pkg::ENT_W-1:0]          entry_price;
    logic [opb_pkg::ENT_W-1:0]          entry_quantity;
    logic [opb_pkg::ECNT_W-1:0]         entry_count;
    logic                               last;

    modport source (output valid, status, has_entry, entry_position, entry_price,
                    entry_quantity, entry_count, last, input ready);
    modport sink   (input valid, status, has_entry, entry_position, entry_price,
                    entry_quantity, entry_count, last, output ready);
endinterface

// ===== rtl/opb_cell.sv =====
// ----------------------------------------------------------------------------
// opb_cell
// One book slot: holds an offer and takes its own, its neighbours', the
// head's or the written value according to the broadcast operation.
// ----------------------------------------------------------------------------
module opb_cell (
    input  logic                        clk,
    input  logic [opb_pkg::IDX_W-1:0]   idx,
    input  opb_pkg::cell_ctrl_t         ctrl,
    input  opb_pkg::entry_t             prev_entry,
    input  opb_pkg::entry_t             next_entry,
    input  opb_pkg::entry_t             head_entry,
    output opb_pkg::entry_t             entry
);

    opb_pkg::entry_t entry_reg;
    opb_pkg::entry_t entry_next;

    // Select the next content of this slot
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            opb_pkg::CELL_INS:
            begin
                if (idx == ctrl.slot)
                    entry_next = ctrl.wr;
                else if (idx > ctrl.slot)
                    entry_next = prev_entry;
            end
            opb_pkg::CELL_MOD:
            begin
                if (idx == ctrl.slot)
                begin
                    if (!ctrl.keep_price)
                        entry_next.price = ctrl.wr.price;
                    if (!ctrl.keep_quantity)
                        entry_next.quantity = ctrl.wr.quantity;
                end
            end
            opb_pkg::CELL_DEL:
            begin
                if (idx >= ctrl.slot)
                    entry_next = next_entry;
            end
            opb_pkg::CELL_ROT:
            begin
                // Rotate the filled part left; the tail takes the old head
                if (idx == ctrl.tail)
                    entry_next = head_entry;
                else if (idx < ctrl.tail)
                    entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/positional_order_book_core.sv =====
// ----------------------------------------------------------------------------
// positional_order_book_core
// Book of up to DEPTH offers kept in a chain of slot cells, addressed by
// 1-based position; insert, modify, delete and dump requests.
//
//   channel | direction | word
//   req     | in        | req_type, position, price, quantity
//   rsp     | out       | status, has_entry, entry_position, entry_price,
//           |           | entry_quantity, entry_count, last
//
// Insert, modify, delete and rejected requests give one word in the
// response register the cycle after acceptance. A dump gives max(1, fill)
// words, one per cycle while the response is not stalled; the chain rotates
// one slot per word and is back in order after the last one. No request is
// taken meanwhile. Requests are taken while the response register is free
// or being drained. Reset empties the book; slot contents need no clearing.
// ----------------------------------------------------------------------------
module positional_order_book_core (
    input  logic         clk,
    input  logic         rst_n,
    opb_req_if.sink      req,
    opb_rsp_if.source    rsp
);

    opb_pkg::ctl_state_t          state_reg, state_next;
    logic [opb_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic [opb_pkg::IDX_W-1:0]    dump_idx_reg, dump_idx_next;

    logic                         rsp_valid_reg;
    logic                         rsp_load;
    logic [opb_pkg::STS_W-1:0]    rsp_status_reg, rsp_status_next;
    logic                         rsp_has_reg, rsp_has_next;
    logic [opb_pkg::EPOS_W-1:0]   rsp_pos_reg, rsp_pos_next;
    opb_pkg::entry_t              rsp_entry_reg, rsp_entry_next;
    logic [opb_pkg::ECNT_W-1:0]   rsp_cnt_reg, rsp_cnt_next;
    logic                         rsp_last_reg, rsp_last_next;

    opb_pkg::cell_ctrl_t          ctrl;
    opb_pkg::entry_t              cell_q [opb_pkg::DEPTH];

    logic                         out_free;
    logic                         in_fire;
    logic [opb_pkg::POS_W-2:0]    pos_u;
    logic [opb_pkg::POS_W-2:0]    pos_m1;
    logic                         pos_over;
    logic [opb_pkg::IDX_W-1:0]    tail_idx;
    logic [opb_pkg::STS_W-1:0]    req_status;
    logic                         dump_last;

    // Handshake
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == opb_pkg::ST_IDLE) && out_free;
    assign in_fire   = req.valid && req.ready;

    // Decode the request word
    assign pos_u    = req.position[opb_pkg::POS_W-2:0];
    assign pos_m1   = pos_u - 1'b1;
    assign pos_over = opb_pkg::CMP_W'(pos_u) > opb_pkg::CMP_W'(fill_reg);
    assign tail_idx = opb_pkg::IDX_W'(fill_reg - 1'b1);
    assign dump_last = (dump_idx_reg == tail_idx);

    always_comb
    begin
        if (req.position[opb_pkg::POS_W-1])
            req_status = opb_pkg::STS_BAD_POS;
        else if (req.price[opb_pkg::VAL_W-1])
            req_status = opb_pkg::STS_BAD_PRICE;
        else if (req.quantity[opb_pkg::VAL_W-1])
            req_status = opb_pkg::STS_BAD_QTY;
        else if (req.req_type == opb_pkg::REQ_DUMP)
            req_status = opb_pkg::STS_OK;
        else if (pos_u == '0)
            req_status = opb_pkg::STS_BAD_POS;
        else if (req.req_type == opb_pkg::REQ_INSERT)
            req_status = (fill_reg == opb_pkg::CNT_W'(opb_pkg::DEPTH)) ?
                         opb_pkg::STS_FULL : opb_pkg::STS_OK;
        else
            req_status = pos_over ? opb_pkg::STS_NO_ENTRY : opb_pkg::STS_OK;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            opb_pkg::ST_IDLE:
            begin
                if (in_fire && req_status == opb_pkg::STS_OK &&
                    req.req_type == opb_pkg::REQ_DUMP && fill_reg != '0)
                    state_next = opb_pkg::ST_DUMP;
            end
            opb_pkg::ST_DUMP:
            begin
                if (out_free && dump_last)
                    state_next = opb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = opb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: cell operation, fill count and response word
    always_comb
    begin
        ctrl.op             = opb_pkg::CELL_HOLD;
        ctrl.slot           = pos_m1[opb_pkg::IDX_W-1:0];
        ctrl.tail           = tail_idx;
        ctrl.wr.price       = req.price[opb_pkg::ENT_W-1:0];
        ctrl.wr.quantity    = req.quantity[opb_pkg::ENT_W-1:0];
        ctrl.keep_price     = (req.price[opb_pkg::ENT_W-1:0] == '0);
        ctrl.keep_quantity  = (req.quantity[opb_pkg::ENT_W-1:0] == '0);
        fill_next           = fill_reg;
        dump_idx_next       = dump_idx_reg;
        rsp_load            = 1'b0;
        rsp_status_next     = req_status;
        rsp_has_next        = 1'b0;
        rsp_pos_next        = '0;
        rsp_entry_next      = '0;
        rsp_last_next       = 1'b1;

        case (state_reg)
            opb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req.req_type == opb_pkg::REQ_DUMP &&
                        req_status == opb_pkg::STS_OK && fill_reg != '0)
                    begin
                        // Start streaming from the head
                        dump_idx_next = '0;
                    end
                    else
                    begin
                        rsp_load = 1'b1;
                        if (req_status == opb_pkg::STS_OK)
                        begin
                            case (req.req_type)
                                opb_pkg::REQ_INSERT:
                                begin
                                    ctrl.op   = opb_pkg::CELL_INS;
                                    fill_next = fill_reg + 1'b1;
                                    if (pos_over)
                                        ctrl.slot = fill_reg[opb_pkg::IDX_W-1:0];
                                end
                                opb_pkg::REQ_MODIFY:
                                begin
                                    ctrl.op = opb_pkg::CELL_MOD;
                                end
                                opb_pkg::REQ_DELETE:
                                begin
                                    ctrl.op   = opb_pkg::CELL_DEL;
                                    fill_next = fill_reg - 1'b1;
                                end
                                default:
                                begin
                                    ctrl.op = opb_pkg::CELL_HOLD;
                                end
                            endcase
                        end
                    end
                end
            end
            opb_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    // Emit the head and rotate the chain by one
                    rsp_load        = 1'b1;
                    rsp_status_next = opb_pkg::STS_OK;
                    rsp_has_next    = 1'b1;
                    rsp_pos_next    = opb_pkg::EPOS_W'(dump_idx_reg) + 1'b1;
                    rsp_entry_next  = cell_q[0];
                    rsp_last_next   = dump_last;
                    ctrl.op         = opb_pkg::CELL_ROT;
                    dump_idx_next   = dump_idx_reg + 1'b1;
                end
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
        rsp_cnt_next = opb_pkg::ECNT_W'(fill_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= opb_pkg::ST_IDLE;
            fill_reg      <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            dump_idx_reg <= dump_idx_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_has_reg    <= rsp_has_next;
            rsp_pos_reg    <= rsp_pos_next;
            rsp_entry_reg  <= rsp_entry_next;
            rsp_cnt_reg    <= rsp_cnt_next;
            rsp_last_reg   <= rsp_last_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.has_entry      = rsp_has_reg;
    assign rsp.entry_position = rsp_pos_reg;
    assign rsp.entry_price    = rsp_entry_reg.price;
    assign rsp.entry_quantity = rsp_entry_reg.quantity;
    assign rsp.entry_count    = rsp_cnt_reg;
    assign rsp.last           = rsp_last_reg;

    // Chain of slot cells; the ends see themselves as outer neighbours
    for (genvar i = 0; i < opb_pkg::DEPTH; i++)
    begin : g_cell
        opb_cell u_cell (
            .clk        (clk),
            .idx        (opb_pkg::IDX_W'(i)),
            .ctrl       (ctrl),
            .prev_entry (cell_q[(i == 0) ? 0 : i - 1]),
            .next_entry (cell_q[(i == opb_pkg::DEPTH - 1) ? i : i + 1]),
            .head_entry (cell_q[0]),
            .entry      (cell_q[i])
        );
    end

endmodule

// ===== rtl/opb_checker.sv =====
// ----------------------------------------------------------------------------
// opb_checker
// Port-level checks of the order book core, attached by bind.
// ----------------------------------------------------------------------------
module opb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [opb_pkg::STS_W-1:0]     rsp_status,
    input  logic                          rsp_has_entry,
    input  logic [opb_pkg::EPOS_W-1:0]    rsp_entry_position,
    input  logic [opb_pkg::ECNT_W-1:0]    rsp_entry_count,
    input  logic                          rsp_last
);

    // A stalled word keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_position)
            && $stable(rsp_status) && $stable(rsp_last))
        else $error("response word changed while stalled");

    // A word without an entry always closes its request
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_has_entry |-> rsp_last)
        else $error("non-entry word not marked last");

    // Dumped entries are good, 1-based and within the book
    a_entry_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_has_entry |-> rsp_status == opb_pkg::STS_OK
            && rsp_entry_position != '0 && rsp_entry_position <= rsp_entry_count)
        else $error("dumped entry out of range");

    // No request is taken in the middle of a dump
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last |-> !(req_valid && req_ready))
        else $error("request accepted during dump");

    // Consecutive dump words count up by one
    a_dump_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_has_entry
            && (rsp_entry_position == $past(rsp_entry_position) + 1'b1))
        else $error("dump sequence broken");

endmodule

bind positional_order_book_core opb_checker u_opb_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_has_entry      (rsp.has_entry),
    .rsp_entry_position (rsp.entry_position),
    .rsp_entry_count    (rsp.entry_count),
    .rsp_last           (rsp.last)
);
